// ===== rtl/mmd_pkg.sv =====
package mmd_pkg;

  localparam int unsigned MAX_SLOTS     = 16;
  localparam int unsigned ROM_SLOTS_DEF = 16;
  localparam int unsigned CFG_DW        = 16;
  localparam int unsigned CFG_IW        = 2;

  typedef enum logic [CFG_IW-1:0] {
    CFG_RAM_128K    = 2'd0,
    CFG_DISC_FITTED = 2'd1,
    CFG_FITTED_ROMS = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    CMD_MEM_RD  = 3'd0,
    CMD_MEM_WR  = 3'd1,
    CMD_IO_WR   = 3'd2,
    CMD_IO_RD   = 3'd3,
    CMD_ROM_EN  = 3'd4,
    CMD_VID     = 3'd5
  } cmd_e;

  typedef enum logic [2:0] {
    TGT_RAM    = 3'd0,
    TGT_LOWER  = 3'd1,
    TGT_UPPER  = 3'd2,
    TGT_ABSENT = 3'd3,
    TGT_NONE   = 3'd4
  } tgt_e;

  localparam int unsigned SEL_PAL   = 0;
  localparam int unsigned SEL_GA    = 1;
  localparam int unsigned SEL_CRTC  = 2;
  localparam int unsigned SEL_ROM   = 3;
  localparam int unsigned SEL_PPI   = 4;
  localparam int unsigned SEL_MOTOR = 5;
  localparam int unsigned SEL_FDC   = 6;

  typedef struct packed {
    logic [2:0]  command;
    logic [15:0] address;
    logic [7:0]  data;
    logic        lower_rom_enable;
    logic        upper_rom_enable;
    logic [13:0] char_address;
    logic [4:0]  raster_line;
  } req_t;

  typedef struct packed {
    logic [2:0]  target;
    logic [16:0] memory_address;
    logic [3:0]  rom_slot;
    logic [6:0]  device_selects;
    logic        crtc_register_select;
    logic        crtc_read_write;
    logic [1:0]  ppi_port;
    logic        fdc_register;
    logic        floppy_motor;
  } res_t;

  typedef struct packed {
    logic       bank_we;
    logic [2:0] bank;
    logic       rom_we;
    logic [7:0] rom;
    logic       en_we;
    logic       lower_on;
    logic       upper_on;
  } upd_t;

  function automatic logic [2:0] bank_lookup(logic [2:0] mode, logic [1:0] quad);
    logic [2:0] bank;
    bank = {1'b0, quad};
    unique case (mode)
      3'd0: bank = {1'b0, quad};
      3'd1: bank = (quad == 2'd3) ? 3'd7 : {1'b0, quad};
      3'd2: bank = {1'b1, quad};
      3'd3: begin
        unique case (quad)
          2'd0: bank = 3'd0;
          2'd1: bank = 3'd3;
          2'd2: bank = 3'd2;
          default: bank = 3'd7;
        endcase
      end
      default: bank = (quad == 2'd1) ? mode : {1'b0, quad};
    endcase
    return bank;
  endfunction

endpackage

// ===== rtl/mmd_req_if.sv =====
interface mmd_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  command;
  logic [15:0] address;
  logic [7:0]  data;
  logic        lower_rom_enable;
  logic        upper_rom_enable;
  logic [13:0] char_address;
  logic [4:0]  raster_line;

  modport source (
    output valid, command, address, data, lower_rom_enable, upper_rom_enable,
           char_address, raster_line,
    input  ready
  );
  modport sink (
    input  valid, command, address, data, lower_rom_enable, upper_rom_enable,
           char_address, raster_line,
    output ready
  );
endinterface

// ===== rtl/mmd_rsp_if.sv =====
interface mmd_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  target;
  logic [16:0] memory_address;
  logic [3:0]  rom_slot;
  logic [6:0]  device_selects;
  logic        crtc_register_select;
  logic        crtc_read_write;
  logic [1:0]  ppi_port;
  logic        fdc_register;
  logic        floppy_motor;

  modport source (
    output valid, target, memory_address, rom_slot, device_selects,
           crtc_register_select, crtc_read_write, ppi_port, fdc_register,
           floppy_motor,
    input  ready
  );
  modport sink (
    input  valid, target, memory_address, rom_slot, device_selects,
           crtc_register_select, crtc_read_write, ppi_port, fdc_register,
           floppy_motor,
    output ready
  );
endinterface

// ===== rtl/memory_map_and_io_decoder.sv =====
// Bus decoder with bank switching and ROM overlays.
// req_i: one beat per CPU or video access (command, address, data, ROM
//   enables, CRTC MA/RA). rsp_o: one beat per request with the decoded
//   target, physical address or ROM offset, ROM slot and I/O chip selects.
// Config: cfg_we_i/cfg_idx_i/cfg_data_i write ram_128k, disc_fitted and the
//   fitted ROM mask; write only while no request is in flight.
// Path: a request beat goes into the input register, then is decoded into
//   the response register. Throughput: one beat per cycle while rsp_o.ready
//   is high; decode is a single pass of logic.
// Bank mode, ROM number and ROM enables change when the request that writes
//   them is decoded, so the very next request already sees them.
// Reset: bank mode 0, ROM number 0, both ROM enables on, config cleared,
//   both pipeline stages empty.
// Stall: while rsp_o.ready is low a pending response holds; the input stage
//   still takes one beat, then req_i.ready drops until the response moves.
module memory_map_and_io_decoder #(
  parameter int unsigned ROM_SLOTS = mmd_pkg::ROM_SLOTS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [mmd_pkg::CFG_IW-1:0]  cfg_idx_i,
  input  logic [mmd_pkg::CFG_DW-1:0]  cfg_data_i,
  mmd_req_if.sink                     req_i,
  mmd_rsp_if.source                   rsp_o
);
  import mmd_pkg::*;

  logic                 in_vld_q;
  req_t                 req_q;
  logic                 out_vld_q;
  res_t                 res_q;
  res_t                 res_d;
  upd_t                 upd;
  logic                 acc;
  logic                 adv;

  logic                 ram_128k_q;
  logic                 disc_fitted_q;
  logic [ROM_SLOTS-1:0] fitted_q;
  logic [2:0]           bank_mode_q;
  logic [7:0]           rom_choice_q;
  logic                 lower_on_q;
  logic                 upper_on_q;

  assign adv         = in_vld_q && (!out_vld_q || rsp_o.ready);
  assign req_i.ready = !in_vld_q || adv;
  assign acc         = req_i.valid && req_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (acc) begin
        in_vld_q <= 1'b1;
      end else if (adv) begin
        in_vld_q <= 1'b0;
      end
      if (adv) begin
        out_vld_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      req_q <= '{command: req_i.command, address: req_i.address, data: req_i.data,
                 lower_rom_enable: req_i.lower_rom_enable,
                 upper_rom_enable: req_i.upper_rom_enable,
                 char_address: req_i.char_address, raster_line: req_i.raster_line};
    end
    if (adv) begin
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ram_128k_q    <= 1'b0;
      disc_fitted_q <= 1'b0;
      fitted_q      <= '0;
      bank_mode_q   <= '0;
      rom_choice_q  <= '0;
      lower_on_q    <= 1'b1;
      upper_on_q    <= 1'b1;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_RAM_128K:    ram_128k_q    <= cfg_data_i[0];
          CFG_DISC_FITTED: disc_fitted_q <= cfg_data_i[0];
          CFG_FITTED_ROMS: fitted_q      <= cfg_data_i[ROM_SLOTS-1:0];
          default: ;
        endcase
      end
      if (adv && upd.bank_we) begin
        bank_mode_q <= upd.bank;
      end
      if (adv && upd.rom_we) begin
        rom_choice_q <= upd.rom;
      end
      if (adv && upd.en_we) begin
        lower_on_q <= upd.lower_on;
        upper_on_q <= upd.upper_on;
      end
    end
  end

  mmd_decode #(
    .ROM_SLOTS(ROM_SLOTS)
  ) u_decode (
    .req_i         (req_q),
    .ram_128k_i    (ram_128k_q),
    .disc_fitted_i (disc_fitted_q),
    .fitted_roms_i (fitted_q),
    .bank_mode_i   (bank_mode_q),
    .rom_choice_i  (rom_choice_q),
    .lower_on_i    (lower_on_q),
    .upper_on_i    (upper_on_q),
    .res_o         (res_d),
    .upd_o         (upd)
  );

  assign rsp_o.valid                = out_vld_q;
  assign rsp_o.target               = res_q.target;
  assign rsp_o.memory_address       = res_q.memory_address;
  assign rsp_o.rom_slot             = res_q.rom_slot;
  assign rsp_o.device_selects       = res_q.device_selects;
  assign rsp_o.crtc_register_select = res_q.crtc_register_select;
  assign rsp_o.crtc_read_write      = res_q.crtc_read_write;
  assign rsp_o.ppi_port             = res_q.ppi_port;
  assign rsp_o.fdc_register         = res_q.fdc_register;
  assign rsp_o.floppy_motor         = res_q.floppy_motor;

  a_sel_only_io: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && res_q.device_selects != '0 |-> res_q.target == TGT_NONE)
    else $error("chip select on a non-io beat");

  a_rom_en_upd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && req_q.command == CMD_ROM_EN |=>
      lower_on_q == $past(req_q.lower_rom_enable)
      && upper_on_q == $past(req_q.upper_rom_enable))
    else $error("rom enables not updated");

  a_bank_needs_128k: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && !ram_128k_q |=> bank_mode_q == $past(bank_mode_q))
    else $error("bank mode changed without 128K");

  a_stage_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !rsp_o.ready |=> out_vld_q && $stable(res_q))
    else $error("stalled response lost");

endmodule

// ===== rtl/mmd_decode.sv =====
module mmd_decode #(
  parameter int unsigned ROM_SLOTS = mmd_pkg::ROM_SLOTS_DEF
) (
  input  mmd_pkg::req_t         req_i,
  input  logic                  ram_128k_i,
  input  logic                  disc_fitted_i,
  input  logic [ROM_SLOTS-1:0]  fitted_roms_i,
  input  logic [2:0]            bank_mode_i,
  input  logic [7:0]            rom_choice_i,
  input  logic                  lower_on_i,
  input  logic                  upper_on_i,
  output mmd_pkg::res_t         res_o,
  output mmd_pkg::upd_t         upd_o
);
  import mmd_pkg::*;

  localparam int unsigned SlotW = $clog2(MAX_SLOTS);

  logic [MAX_SLOTS-1:0] fit_all;
  logic                 choice_fit;
  logic [16:0]          ram_addr;
  logic [16:0]          rom_off;
  logic [15:0]          a;
  cmd_e                 cmd;

  assign a        = req_i.address;
  assign cmd      = cmd_e'(req_i.command);
  assign fit_all  = MAX_SLOTS'(fitted_roms_i);
  assign choice_fit = (rom_choice_i[7:SlotW] == '0)
                   && ({1'b0, rom_choice_i[SlotW-1:0]} < (SlotW+1)'(ROM_SLOTS))
                   && fit_all[rom_choice_i[SlotW-1:0]];
  assign ram_addr = {bank_lookup(bank_mode_i, a[15:14]), a[13:0]};
  assign rom_off  = {3'b000, a[13:0]};

  always_comb begin
    res_o        = '0;
    res_o.target = TGT_NONE;
    upd_o        = '0;
    unique case (cmd)
      CMD_MEM_RD: begin
        if (a[15:14] == 2'd0 && lower_on_i) begin
          res_o.target         = TGT_LOWER;
          res_o.memory_address = rom_off;
        end else if (a[15:14] == 2'd3 && upper_on_i) begin
          if (choice_fit) begin
            res_o.target         = TGT_UPPER;
            res_o.rom_slot       = rom_choice_i[3:0];
            res_o.memory_address = rom_off;
          end else if (fitted_roms_i[0]) begin
            res_o.target         = TGT_UPPER;
            res_o.memory_address = rom_off;
          end else begin
            res_o.target = TGT_ABSENT;
          end
        end else begin
          res_o.target         = TGT_RAM;
          res_o.memory_address = ram_addr;
        end
      end
      CMD_MEM_WR: begin
        res_o.target         = TGT_RAM;
        res_o.memory_address = ram_addr;
      end
      CMD_IO_WR: begin
        if (!a[15] && req_i.data[7:6] == 2'b11 && ram_128k_i) begin
          res_o.device_selects[SEL_PAL] = 1'b1;
          upd_o.bank_we = 1'b1;
          upd_o.bank    = req_i.data[2:0];
        end
        if (a[15:14] == 2'b01) begin
          res_o.device_selects[SEL_GA] = 1'b1;
        end
        if (!a[14]) begin
          res_o.device_selects[SEL_CRTC] = 1'b1;
          res_o.crtc_register_select     = a[8];
          res_o.crtc_read_write          = a[9];
        end
        if (!a[13]) begin
          res_o.device_selects[SEL_ROM] = 1'b1;
          upd_o.rom_we = 1'b1;
          upd_o.rom    = req_i.data;
        end
        if (!a[11]) begin
          res_o.device_selects[SEL_PPI] = 1'b1;
          res_o.ppi_port                = a[9:8];
        end
        if (disc_fitted_i && !a[10] && !a[7]) begin
          if (a[8]) begin
            res_o.device_selects[SEL_FDC] = 1'b1;
            res_o.fdc_register            = a[0];
          end else begin
            res_o.device_selects[SEL_MOTOR] = 1'b1;
            res_o.floppy_motor              = req_i.data[0];
          end
        end
      end
      CMD_IO_RD: begin
        if (!a[14]) begin
          res_o.device_selects[SEL_CRTC] = 1'b1;
          res_o.crtc_register_select     = a[8];
          res_o.crtc_read_write          = a[9];
        end
        if (!a[11]) begin
          res_o.device_selects[SEL_PPI] = 1'b1;
          res_o.ppi_port                = a[9:8];
        end
        if (disc_fitted_i && !a[10] && a[8] && !a[7]) begin
          res_o.device_selects[SEL_FDC] = 1'b1;
          res_o.fdc_register            = a[0];
        end
      end
      CMD_ROM_EN: begin
        upd_o.en_we    = 1'b1;
        upd_o.lower_on = req_i.lower_rom_enable;
        upd_o.upper_on = req_i.upper_rom_enable;
      end
      CMD_VID: begin
        res_o.target         = TGT_RAM;
        res_o.memory_address = {1'b0, req_i.char_address[13:12], req_i.raster_line[2:0],
                                req_i.char_address[9:0], 1'b0};
      end
      default: ;
    endcase
  end

endmodule

// ===== dv/tb_memory_map_and_io_decoder.sv =====
module tb_memory_map_and_io_decoder;
  timeunit 1ns;
  timeprecision 1ps;

  import mmd_pkg::*;

  localparam logic [2:0]  CMD_SPARE_6 = 3'd6;
  localparam logic [2:0]  CMD_SPARE_7 = 3'd7;
  localparam int unsigned PHASES      = 8;
  localparam int unsigned PHASE_BEATS = 232;
  localparam int unsigned HOLD_AT     = 400;
  localparam int unsigned HOLD_CYCLES = 80;
  localparam int unsigned STEADY_FROM = 900;
  localparam int unsigned STEADY_TO   = 1150;
  localparam int unsigned QUIET_LIMIT = 2000;
  localparam int unsigned IDLE_PCT    = 31;
  localparam int unsigned MAX_REPORTS = 10;

  // RAM bank per quadrant, one octal digit each; mode 0 in the low bits
  localparam logic [95:0] BANK_MAP = {12'o3270, 12'o3260, 12'o3250, 12'o3240,
                                      12'o7230, 12'o7654, 12'o7210, 12'o3210};

  typedef struct packed {
    logic        is_reg;
    cfg_idx_e    reg_idx;
    logic [15:0] reg_val;
    req_t        access;
    logic        typed;
    res_t        typed_rsp;
  } script_row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CFG_IW-1:0]   cfg_idx_i;
  logic [CFG_DW-1:0]   cfg_data_i;

  mmd_req_if req_if ();
  mmd_rsp_if rsp_if ();

  logic [2:0]  bank_sel;
  logic [7:0]  rom_pick;
  logic        low_rom_live;
  logic        up_rom_live;
  logic        has_128k;
  logic        has_disc;
  logic [15:0] slot_mask;

  res_t        decodes_due[$];
  int unsigned fail_count   = 0;
  int unsigned quiet_cycles = 0;
  logic        steady       = 1'b0;
  logic        hold_go      = 1'b0;

  always #5 clk_i = ~clk_i;

  memory_map_and_io_decoder DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .req_i      (req_if),
    .rsp_o      (rsp_if)
  );

  function automatic logic slot_live(logic [7:0] n);
    return ({24'd0, n} < ROM_SLOTS_DEF) && slot_mask[n[3:0]];
  endfunction

  function automatic logic [16:0] ram_phys(logic [15:0] a);
    int base;
    base = 12 * int'(bank_sel) + 3 * int'(a[15:14]);
    return {BANK_MAP[base +: 3], a[13:0]};
  endfunction

  function automatic res_t decode_access(req_t r);
    res_t        o;
    logic [15:0] a;
    logic [7:0]  d;
    a = r.address;
    d = r.data;
    o = '0;
    o.target = TGT_NONE;
    case (r.command)
      CMD_MEM_RD: begin
        if (a[15:14] == 2'd0 && low_rom_live) begin
          o.target         = TGT_LOWER;
          o.memory_address = {3'd0, a[13:0]};
        end else if (a[15:14] == 2'd3 && up_rom_live) begin
          if (slot_live(rom_pick) || slot_live(8'd0)) begin
            o.target         = TGT_UPPER;
            o.rom_slot       = slot_live(rom_pick) ? rom_pick[3:0] : 4'd0;
            o.memory_address = {3'd0, a[13:0]};
          end else begin
            o.target = TGT_ABSENT;
          end
        end else begin
          o.target         = TGT_RAM;
          o.memory_address = ram_phys(a);
        end
      end
      CMD_MEM_WR: begin
        o.target         = TGT_RAM;
        o.memory_address = ram_phys(a);
      end
      CMD_IO_WR: begin
        if (!a[15] && d[7:6] == 2'b11 && has_128k) begin
          o.device_selects[SEL_PAL] = 1'b1;
          bank_sel = d[2:0];
        end
        o.device_selects[SEL_GA] = (a[15:14] == 2'b01);
        if (!a[14]) begin
          o.device_selects[SEL_CRTC] = 1'b1;
          o.crtc_register_select     = a[8];
          o.crtc_read_write          = a[9];
        end
        if (!a[13]) begin
          o.device_selects[SEL_ROM] = 1'b1;
          rom_pick = d;
        end
        if (!a[11]) begin
          o.device_selects[SEL_PPI] = 1'b1;
          o.ppi_port                = a[9:8];
        end
        if (has_disc && !a[10] && !a[7]) begin
          if (a[8]) begin
            o.device_selects[SEL_FDC] = 1'b1;
            o.fdc_register            = a[0];
          end else begin
            o.device_selects[SEL_MOTOR] = 1'b1;
            o.floppy_motor              = d[0];
          end
        end
      end
      CMD_IO_RD: begin
        if (!a[14]) begin
          o.device_selects[SEL_CRTC] = 1'b1;
          o.crtc_register_select     = a[8];
          o.crtc_read_write          = a[9];
        end
        if (!a[11]) begin
          o.device_selects[SEL_PPI] = 1'b1;
          o.ppi_port                = a[9:8];
        end
        if (has_disc && !a[10] && a[8] && !a[7]) begin
          o.device_selects[SEL_FDC] = 1'b1;
          o.fdc_register            = a[0];
        end
      end
      CMD_ROM_EN: begin
        low_rom_live = r.lower_rom_enable;
        up_rom_live  = r.upper_rom_enable;
      end
      CMD_VID: begin
        o.target         = TGT_RAM;
        o.memory_address = {1'b0, r.char_address[13:12], r.raster_line[2:0],
                            r.char_address[9:0], 1'b0};
      end
      default: ;
    endcase
    return o;
  endfunction

  function automatic req_t random_access();
    req_t        r;
    int unsigned pick;
    r.command          = CMD_MEM_RD;
    r.address          = 16'($urandom());
    r.data             = 8'($urandom());
    r.lower_rom_enable = 1'($urandom());
    r.upper_rom_enable = 1'($urandom());
    r.char_address     = 14'($urandom());
    r.raster_line      = 5'($urandom());
    pick = $urandom_range(0, 99);
    if (pick < 28) begin
      r.command = CMD_MEM_RD;
    end else if (pick < 42) begin
      r.command = CMD_MEM_WR;
    end else if (pick < 62) begin
      r.command = CMD_IO_WR;
      case ($urandom_range(0, 4))
        0: begin
          // bank mode write that also selects the gate array and nothing else
          r.address[15:8] = 8'h7F;
          r.data[7:6]     = 2'b11;
        end
        1: begin
          r.address[15:8] = 8'hDF;
          if ($urandom_range(0, 3) != 0) r.data = 8'($urandom_range(0, 17));
        end
        2: begin
          // motor or FDC port
          r.address[15:9] = 7'b1111101;
          r.address[7]    = 1'b0;
        end
        3: r.address[15:8] = 8'h7F;
        default: ;
      endcase
    end else if (pick < 72) begin
      r.command = CMD_IO_RD;
    end else if (pick < 80) begin
      r.command = CMD_ROM_EN;
    end else if (pick < 97) begin
      r.command = CMD_VID;
    end else begin
      r.command = ($urandom_range(0, 1) != 0) ? CMD_SPARE_6 : CMD_SPARE_7;
    end
    return r;
  endfunction

  function automatic script_row_t reg_row(cfg_idx_e idx, logic [15:0] value);
    script_row_t s;
    s         = '0;
    s.is_reg  = 1'b1;
    s.reg_idx = idx;
    s.reg_val = value;
    return s;
  endfunction

  function automatic script_row_t bus_row(logic [2:0] cmd, logic [15:0] a, logic [7:0] d);
    script_row_t s;
    s                = '0;
    s.access.command = cmd;
    s.access.address = a;
    s.access.data    = d;
    return s;
  endfunction

  function automatic script_row_t en_row(logic lower_on, logic upper_on);
    script_row_t s;
    s                         = '0;
    s.access.command          = CMD_ROM_EN;
    s.access.lower_rom_enable = lower_on;
    s.access.upper_rom_enable = upper_on;
    return s;
  endfunction

  function automatic script_row_t vid_row(logic [13:0] ma, logic [4:0] ra);
    script_row_t s;
    s                     = '0;
    s.access.command      = CMD_VID;
    s.access.char_address = ma;
    s.access.raster_line  = ra;
    return s;
  endfunction

  function automatic script_row_t with_rsp(script_row_t s, tgt_e t, logic [16:0] addr);
    s.typed                    = 1'b1;
    s.typed_rsp                = '0;
    s.typed_rsp.target         = t;
    s.typed_rsp.memory_address = addr;
    return s;
  endfunction

  task automatic offer(input req_t r, input logic typed, input res_t typed_rsp);
    res_t predicted;
    while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid            <= 1'b1;
    req_if.command          <= r.command;
    req_if.address          <= r.address;
    req_if.data             <= r.data;
    req_if.lower_rom_enable <= r.lower_rom_enable;
    req_if.upper_rom_enable <= r.upper_rom_enable;
    req_if.char_address     <= r.char_address;
    req_if.raster_line      <= r.raster_line;
    do @(posedge clk_i); while (req_if.ready !== 1'b1);
    predicted = decode_access(r);
    decodes_due.push_back(typed ? typed_rsp : predicted);
  endtask

  task automatic settle();
    req_if.valid <= 1'b0;
    while (decodes_due.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [15:0] value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_RAM_128K:    has_128k  = value[0];
      CFG_DISC_FITTED: has_disc  = value[0];
      default:         slot_mask = value;
    endcase
    @(posedge clk_i);
  endtask

  task automatic configure(input logic big, input logic disc, input logic [15:0] mask);
    settle();
    write_reg(CFG_RAM_128K, {15'd0, big});
    write_reg(CFG_DISC_FITTED, {15'd0, disc});
    write_reg(CFG_FITTED_ROMS, mask);
  endtask

  function automatic logic field_off(string name, logic [16:0] want, logic [16:0] got);
    if (want === got) return 1'b0;
    if (fail_count < MAX_REPORTS)
      $display("%0t %s: expected %0h, got %0h", $time, name, want, got);
    return 1'b1;
  endfunction

  always @(posedge clk_i) begin : score
    res_t got;
    res_t want;
    logic bad;
    if (rst_ni === 1'b1 && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
      got.target               = rsp_if.target;
      got.memory_address       = rsp_if.memory_address;
      got.rom_slot             = rsp_if.rom_slot;
      got.device_selects       = rsp_if.device_selects;
      got.crtc_register_select = rsp_if.crtc_register_select;
      got.crtc_read_write      = rsp_if.crtc_read_write;
      got.ppi_port             = rsp_if.ppi_port;
      got.fdc_register         = rsp_if.fdc_register;
      got.floppy_motor         = rsp_if.floppy_motor;
      if (decodes_due.size() == 0) begin
        if (fail_count < MAX_REPORTS) $display("%0t response beat with none pending", $time);
        fail_count++;
      end else begin
        want = decodes_due.pop_front();
        bad  = field_off("target", 17'(want.target), 17'(got.target));
        bad |= field_off("memory_address", want.memory_address, got.memory_address);
        bad |= field_off("rom_slot", 17'(want.rom_slot), 17'(got.rom_slot));
        bad |= field_off("device_selects", 17'(want.device_selects),
                         17'(got.device_selects));
        bad |= field_off("crtc_register_select", 17'(want.crtc_register_select),
                         17'(got.crtc_register_select));
        bad |= field_off("crtc_read_write", 17'(want.crtc_read_write),
                         17'(got.crtc_read_write));
        bad |= field_off("ppi_port", 17'(want.ppi_port), 17'(got.ppi_port));
        bad |= field_off("fdc_register", 17'(want.fdc_register), 17'(got.fdc_register));
        bad |= field_off("floppy_motor", 17'(want.floppy_motor), 17'(got.floppy_motor));
        if (bad) fail_count++;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni !== 1'b1 || (req_if.valid === 1'b1 && req_if.ready === 1'b1) ||
        (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : rsp_side
    int unsigned hold_left;
    logic        held;
    hold_left = 0;
    held      = 1'b0;
    rsp_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (hold_go && !held) begin
        held      = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  initial begin : req_side
    script_row_t script[$];
    int unsigned n;
    req_if.valid            <= 1'b0;
    req_if.command          <= CMD_MEM_RD;
    req_if.address          <= '0;
    req_if.data             <= '0;
    req_if.lower_rom_enable <= 1'b0;
    req_if.upper_rom_enable <= 1'b0;
    req_if.char_address     <= '0;
    req_if.raster_line      <= '0;
    cfg_we_i                <= 1'b0;
    cfg_idx_i               <= CFG_RAM_128K;
    cfg_data_i              <= '0;
    rst_ni                  <= 1'b0;
    bank_sel     = 3'd0;
    rom_pick     = 8'd0;
    low_rom_live = 1'b1;
    up_rom_live  = 1'b1;
    has_128k     = 1'b0;
    has_disc     = 1'b0;
    slot_mask    = '0;

    script = '{
      with_rsp(bus_row(CMD_MEM_RD, 16'h0000, 8'h00), TGT_LOWER, 17'h00000),
      with_rsp(bus_row(CMD_MEM_RD, 16'h3FFF, 8'hFF), TGT_LOWER, 17'h03FFF),
      with_rsp(bus_row(CMD_MEM_RD, 16'hFFFF, 8'h00), TGT_ABSENT, 17'h00000),
      bus_row(CMD_MEM_RD, 16'h8000, 8'h00),
      with_rsp(bus_row(CMD_MEM_WR, 16'hFFFF, 8'hFF), TGT_RAM, 17'h0FFFF),
      with_rsp(bus_row(CMD_SPARE_6, 16'hFFFF, 8'hFF), TGT_NONE, 17'h00000),
      with_rsp(bus_row(CMD_SPARE_7, 16'h0000, 8'h00), TGT_NONE, 17'h00000),
      bus_row(CMD_IO_WR, 16'h7F00, 8'hC7),
      bus_row(CMD_IO_RD, 16'h0000, 8'h00),
      with_rsp(vid_row(14'h3FFF, 5'h1F), TGT_RAM, 17'h0FFFE),
      with_rsp(vid_row(14'h0000, 5'h00), TGT_RAM, 17'h00000),
      reg_row(CFG_RAM_128K, 16'h0001),
      reg_row(CFG_DISC_FITTED, 16'h0001),
      reg_row(CFG_FITTED_ROMS, 16'h8001),
      bus_row(CMD_IO_WR, 16'h7FFF, 8'hC2),
      bus_row(CMD_MEM_RD, 16'h4000, 8'h00),
      bus_row(CMD_MEM_WR, 16'hC123, 8'h5A),
      bus_row(CMD_IO_WR, 16'hDF00, 8'h0F),
      bus_row(CMD_MEM_RD, 16'hC000, 8'h00),
      bus_row(CMD_IO_WR, 16'hDF00, 8'h05),
      bus_row(CMD_MEM_RD, 16'hE000, 8'h00),
      bus_row(CMD_IO_WR, 16'hDF00, 8'hFF),
      with_rsp(en_row(1'b0, 1'b0), TGT_NONE, 17'h00000),
      bus_row(CMD_MEM_RD, 16'h0000, 8'h00),
      with_rsp(en_row(1'b1, 1'b1), TGT_NONE, 17'h00000),
      bus_row(CMD_IO_WR, 16'hFA7E, 8'h01),
      bus_row(CMD_IO_WR, 16'hFB7F, 8'h00),
      bus_row(CMD_IO_RD, 16'hFB7F, 8'h00),
      bus_row(CMD_IO_RD, 16'hBC00, 8'h00),
      bus_row(CMD_IO_RD, 16'hF400, 8'h00),
      bus_row(CMD_IO_WR, 16'h0000, 8'hFF),
      reg_row(CFG_FITTED_ROMS, 16'hFFFE),
      bus_row(CMD_IO_WR, 16'hDF00, 8'h10),
      with_rsp(bus_row(CMD_MEM_RD, 16'hFFFF, 8'h00), TGT_ABSENT, 17'h00000)
    };

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (script[i]) begin
      if (script[i].is_reg) begin
        settle();
        write_reg(script[i].reg_idx, script[i].reg_val);
      end else begin
        offer(script[i].access, script[i].typed, script[i].typed_rsp);
      end
    end

    n = 0;
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0:       configure(1'b1, 1'b1, 16'hFFFF);
        1:       configure(1'b0, 1'b0, 16'h0000);
        2:       configure(1'b1, 1'b1, 16'hFFFE);
        3:       configure(1'b0, 1'b1, 16'h0001);
        default: configure(1'($urandom()), 1'($urandom()), 16'($urandom()));
      endcase
      for (int k = 0; k < PHASE_BEATS; k++) begin
        if (n == HOLD_AT) hold_go <= 1'b1;
        if (n == STEADY_FROM) steady <= 1'b1;
        if (n == STEADY_TO) steady <= 1'b0;
        offer(random_access(), 1'b0, '0);
        n++;
      end
    end

    settle();
    repeat (10) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/mmd_pkg.sv
rtl/mmd_req_if.sv
rtl/mmd_rsp_if.sv
rtl/mmd_decode.sv
rtl/memory_map_and_io_decoder.sv
dv/tb_memory_map_and_io_decoder.sv
